// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted (active-low reset)
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked property that holds through reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/flp_pkg.sv =====
// ----------------------------------------------------------------------------
// flp_pkg
// Shared constants and types for the banked free list pool.
// ----------------------------------------------------------------------------
package flp_pkg;

  // sizes
  localparam int unsigned FLP_MAX_BANKS   = 8;
  localparam int unsigned FLP_ENTRY_COUNT = 1024;
  localparam int unsigned FLP_ID_W        = $clog2(FLP_ENTRY_COUNT);
  localparam int unsigned FLP_LINK_W      = FLP_ID_W + 1;
  localparam int unsigned FLP_BANK_W      = 3;
  localparam int unsigned FLP_CFG_W       = 4;
  localparam int unsigned FLP_ENTRIES_W   = 11;
  localparam int unsigned FLP_STATUS_W    = 2;

  // link word: top bit marks the bottom of a bank
  localparam logic [FLP_LINK_W-1:0] FLP_LINK_END = FLP_LINK_W'(1) << FLP_ID_W;

  // saturation bound of the per-bank entry counters
  localparam logic [FLP_ENTRIES_W-1:0] FLP_ENTRIES_MAX = '1;

  // banks_in_use after reset
  localparam logic [FLP_CFG_W-1:0] FLP_CFG_RESET = FLP_CFG_W'(1);

  // opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  localparam logic [FLP_STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [FLP_STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [FLP_STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // outcome of the round-robin bank search
  typedef struct packed {
    logic                  found;
    logic [FLP_BANK_W-1:0] idx;
  } flp_pick_t;

endpackage

// ===== hw/rtl/flp_link_mem.sv =====
// ----------------------------------------------------------------------------
// flp_link_mem
// Next-link table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module flp_link_mem #(
  parameter int unsigned Depth = flp_pkg::FLP_ENTRY_COUNT,
  parameter int unsigned Width = flp_pkg::FLP_LINK_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/flp_bank_pick.sv =====
// ----------------------------------------------------------------------------
// flp_bank_pick
// Round-robin search over the bank valid bits, starting at a given bank.
// ----------------------------------------------------------------------------
module flp_bank_pick #(
  parameter int unsigned NumBanks = flp_pkg::FLP_MAX_BANKS
) (
  input  logic [NumBanks-1:0]            valid_i,
  input  logic [flp_pkg::FLP_BANK_W-1:0] start_i,
  input  logic [flp_pkg::FLP_CFG_W-1:0]  limit_i,
  output flp_pkg::flp_pick_t             pick_o
);
  import flp_pkg::*;

  logic [NumBanks-1:0]   upper_hit;
  logic [NumBanks-1:0]   lower_hit;
  logic                  upper_found;
  logic                  lower_found;
  logic [FLP_BANK_W-1:0] upper_idx;
  logic [FLP_BANK_W-1:0] lower_idx;

  // split the ring at the start bank: from start up to the limit, then below start
  always_comb begin
    for (int i = 0; i < NumBanks; i++) begin
      upper_hit[i] = valid_i[i] && (FLP_BANK_W'(i) >= start_i) &&
                     (FLP_CFG_W'(i) < limit_i);
      lower_hit[i] = valid_i[i] && (FLP_BANK_W'(i) < start_i);
    end
  end

  // lowest set bit of each half, scanned from the top so the lowest wins
  always_comb begin
    upper_found = 1'b0;
    lower_found = 1'b0;
    upper_idx   = '0;
    lower_idx   = '0;
    for (int i = NumBanks - 1; i >= 0; i--) begin
      if (upper_hit[i]) begin
        upper_found = 1'b1;
        upper_idx   = FLP_BANK_W'(i);
      end
      if (lower_hit[i]) begin
        lower_found = 1'b1;
        lower_idx   = FLP_BANK_W'(i);
      end
    end
  end

  // wrap-around only when nothing is found at or above the start
  always_comb begin
    pick_o.found = upper_found || lower_found;
    pick_o.idx   = upper_found ? upper_idx : lower_idx;
  end

endmodule

// ===== hw/rtl/banked_free_list_pool.sv =====
// ----------------------------------------------------------------------------
// banked_free_list_pool
// Pool of free entry ids kept in LIFO banks linked through a shared table.
// ----------------------------------------------------------------------------
// Usage:
//   A command (opcode_i, bank_i, entry_id_i) is taken at a rising edge where
//   start is high and busy is low. Push puts entry_id_i on top of bank_i; pop
//   takes the top of the first non-empty active bank, searching round-robin
//   from bank_i. A bank at or above banks_in_use is rejected with a status.
//   One result per command appears on status_o, popped_id_o, bank_used_o and
//   nonempty_banks_o for one cycle, marked by done_o; the receiver cannot
//   hold it off. The result passes through the in-flight stage and the result
//   register, and busy is high for the one cycle in between, so a new command
//   is not taken while the previous one is in flight. The busy cycle is set by
//   the next-link memory: a pop reads the link under the bank head and needs
//   its registered read data before the bank head can be updated.
//   banks_in_use is written through cfg_we_i / cfg_wdata_i, by the user only
//   while no command is in flight; the block does not enforce it. Reset empties
//   every bank, clears all counters and sets banks_in_use to 1; the link memory
//   needs no clearing pass since a link is only read after a push has written it.
// ----------------------------------------------------------------------------
module banked_free_list_pool #(
  parameter int unsigned NumBanks = flp_pkg::FLP_MAX_BANKS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [flp_pkg::FLP_CFG_W-1:0]     cfg_wdata_i,
  // command
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode_i,
  input  logic [flp_pkg::FLP_BANK_W-1:0]    bank_i,
  input  logic [flp_pkg::FLP_ID_W-1:0]      entry_id_i,
  // result
  output logic                              done_o,
  output logic [flp_pkg::FLP_STATUS_W-1:0]  status_o,
  output logic [flp_pkg::FLP_ID_W-1:0]      popped_id_o,
  output logic [flp_pkg::FLP_BANK_W-1:0]    bank_used_o,
  output logic [flp_pkg::FLP_CFG_W-1:0]     nonempty_banks_o
);
  import flp_pkg::*;

  localparam int unsigned BankIdxW = (NumBanks > 1) ? $clog2(NumBanks) : 1;
  localparam logic [FLP_CFG_W-1:0] NumBanksC = FLP_CFG_W'(NumBanks);

  // configuration register
  logic [FLP_CFG_W-1:0] cfg_q;
  logic [FLP_CFG_W-1:0] active_n;

  // bank state
  logic [NumBanks-1:0]      valid_q, valid_d;
  logic [FLP_ID_W-1:0]      head_q    [NumBanks];
  logic [FLP_ID_W-1:0]      head_d    [NumBanks];
  logic [FLP_ENTRIES_W-1:0] entries_q [NumBanks];
  logic [FLP_ENTRIES_W-1:0] entries_d [NumBanks];
  logic [FLP_CFG_W-1:0]     nonempty_q, nonempty_d;

  // command decode
  logic                accept;
  logic                range_err;
  logic                do_push;
  logic                do_pop;
  flp_pick_t           pick;
  logic [BankIdxW-1:0] req_idx;
  logic [BankIdxW-1:0] pick_idx;

  // in-flight stage
  logic                    busy_q;
  logic                    st_pop_q;
  logic [FLP_STATUS_W-1:0] st_status_q, st_status_d;
  logic [FLP_BANK_W-1:0]   st_bank_q, st_bank_d;
  logic [FLP_ID_W-1:0]     st_top_q, st_top_d;
  logic [BankIdxW-1:0]     st_idx_q;

  // link memory
  logic [FLP_LINK_W-1:0] link_wdata;
  logic [FLP_LINK_W-1:0] link_rdata;
  logic                  fin_pop;

  // result registers
  logic                    done_q;
  logic [FLP_STATUS_W-1:0] res_status_q;
  logic [FLP_ID_W-1:0]     res_popped_q;
  logic [FLP_BANK_W-1:0]   res_bank_q;
  logic [FLP_CFG_W-1:0]    res_nonempty_q;

  // banks_in_use, saturated to the implemented bank count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= FLP_CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  assign active_n = (cfg_q > NumBanksC) ? NumBanksC : cfg_q;

  // command decode
  assign accept    = start && !busy_q;
  assign range_err = FLP_CFG_W'(bank_i) >= active_n;
  assign do_push   = accept && !range_err && (opcode_i == OP_PUSH);
  assign do_pop    = accept && !range_err && (opcode_i == OP_POP) && pick.found;
  assign req_idx   = bank_i[BankIdxW-1:0];
  assign pick_idx  = pick.idx[BankIdxW-1:0];
  assign fin_pop   = busy_q && st_pop_q;

  flp_bank_pick #(
    .NumBanks (NumBanks)
  ) u_bank_pick (
    .valid_i (valid_q),
    .start_i (bank_i),
    .limit_i (active_n),
    .pick_o  (pick)
  );

  // new link: old head below the pushed id, or the bottom mark for an empty bank
  assign link_wdata = valid_q[req_idx] ? {1'b0, head_q[req_idx]} : FLP_LINK_END;

  flp_link_mem #(
    .Depth (FLP_ENTRY_COUNT),
    .Width (FLP_LINK_W)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (entry_id_i),
    .wdata_i (link_wdata),
    .re_i    (do_pop),
    .raddr_i (head_q[pick_idx]),
    .rdata_o (link_rdata)
  );

  // bank state update: push at the command transfer, pop once the link is back
  always_comb begin
    valid_d    = valid_q;
    head_d     = head_q;
    entries_d  = entries_q;
    nonempty_d = nonempty_q;
    if (do_push) begin
      head_d[req_idx]  = entry_id_i;
      valid_d[req_idx] = 1'b1;
      if (!valid_q[req_idx]) begin
        nonempty_d = nonempty_q + FLP_CFG_W'(1);
      end
      if (entries_q[req_idx] != FLP_ENTRIES_MAX) begin
        entries_d[req_idx] = entries_q[req_idx] + FLP_ENTRIES_W'(1);
      end
    end else if (fin_pop) begin
      if (link_rdata[FLP_ID_W]) begin
        valid_d[st_idx_q] = 1'b0;
        if (nonempty_q != '0) begin
          nonempty_d = nonempty_q - FLP_CFG_W'(1);
        end
      end else begin
        head_d[st_idx_q] = link_rdata[FLP_ID_W-1:0];
      end
      if (entries_q[st_idx_q] != '0) begin
        entries_d[st_idx_q] = entries_q[st_idx_q] - FLP_ENTRIES_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      nonempty_q <= '0;
      for (int i = 0; i < NumBanks; i++) begin
        entries_q[i] <= '0;
      end
    end else begin
      valid_q    <= valid_d;
      nonempty_q <= nonempty_d;
      entries_q  <= entries_d;
    end
  end

  // bank heads are only read while the bank is valid
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
  end

  // result fields decided at the command transfer
  always_comb begin
    st_status_d = STATUS_DONE;
    st_bank_d   = '0;
    st_top_d    = '0;
    if (range_err) begin
      st_status_d = STATUS_RANGE;
    end else if (opcode_i == OP_PUSH) begin
      st_bank_d = bank_i;
    end else if (pick.found) begin
      st_bank_d = pick.idx;
      st_top_d  = head_q[pick_idx];
    end else begin
      st_status_d = STATUS_EMPTY;
    end
  end

  // in-flight control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      st_pop_q <= 1'b0;
    end else if (accept) begin
      busy_q   <= 1'b1;
      st_pop_q <= do_pop;
    end else begin
      busy_q   <= 1'b0;
      st_pop_q <= 1'b0;
    end
  end

  // in-flight payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_status_q <= st_status_d;
      st_bank_q   <= st_bank_d;
      st_top_q    <= st_top_d;
      st_idx_q    <= pick_idx;
    end
  end

  // result register, shown for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q         <= 1'b0;
      res_status_q   <= STATUS_DONE;
      res_popped_q   <= '0;
      res_bank_q     <= '0;
      res_nonempty_q <= '0;
    end else begin
      done_q <= busy_q;
      if (busy_q) begin
        res_status_q   <= st_status_q;
        res_popped_q   <= st_top_q;
        res_bank_q     <= st_bank_q;
        res_nonempty_q <= nonempty_d;
      end
    end
  end

  assign busy             = busy_q;
  assign done_o           = done_q;
  assign status_o         = res_status_q;
  assign popped_id_o      = res_popped_q;
  assign bank_used_o      = res_bank_q;
  assign nonempty_banks_o = res_nonempty_q;

endmodule

// ===== hw/rtl/flp_checker.sv =====
// ----------------------------------------------------------------------------
// flp_checker
// Port-level checks of the banked free list pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_o,
  input logic [flp_pkg::FLP_STATUS_W-1:0]  status_o,
  input logic [flp_pkg::FLP_ID_W-1:0]      popped_id_o,
  input logic [flp_pkg::FLP_BANK_W-1:0]    bank_used_o,
  input logic [flp_pkg::FLP_CFG_W-1:0]     nonempty_banks_o
);
  import flp_pkg::*;

  // every command transfer is followed by one busy cycle and then its result
  `ASSERT_PROP(a_cmd_result, clk_i, rst_ni, (start && !busy) |=> busy ##1 done_o, "command without result two cycles later")

  // a result only follows a busy cycle
  `ASSERT_PROP(a_done_after_busy, clk_i, rst_ni, done_o |-> ($past(busy) && !busy), "result strobe without a command in flight")

  // rejected commands and empty pops carry no id and no bank
  `ASSERT_PROP(a_fail_clean, clk_i, rst_ni, (done_o && (status_o == STATUS_RANGE || status_o == STATUS_EMPTY)) |-> (popped_id_o == '0 && bank_used_o == '0), "failed command reports an id or a bank")

  // status code and bank count stay within their defined values
  `ASSERT_PROP(a_result_range, clk_i, rst_ni, done_o |-> ((status_o == STATUS_DONE || status_o == STATUS_EMPTY || status_o == STATUS_RANGE) && nonempty_banks_o <= FLP_CFG_W'(FLP_MAX_BANKS)), "result field out of range")

  // no result strobe in the cycle after reset is seen
  `ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !done_o, "result strobe right after reset")

endmodule

bind banked_free_list_pool flp_checker u_flp_checker (.*);
